@@ rtl/core/e2r_pkg.sv @@
// Shared types and constants for the Euler-to-rotation-matrix unit.
`timescale 1ns / 1ps
`default_nettype none
package e2r_pkg;
   localparam int ANG_W       = 18;
   localparam int CORDIC_W    = 34;
   localparam int Z_W         = 28;
   localparam int STEPS       = 22;
   localparam int STEP_W      = 5;
   localparam logic signed [ANG_W-1:0]    ANGLE_LIMIT = 18'sd102944;
   localparam logic signed [Z_W-1:0]      Q24_HALF_PI = 28'sd26353589;
   localparam logic signed [Z_W-1:0]      Q24_PI      = 28'sd52707179;
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0   = 34'sd652032874;

   typedef logic signed [CORDIC_W-1:0] q30_type;
   typedef logic signed [Z_W-1:0]      zang_type;

   typedef struct packed {
      q30_type  x;
      q30_type  y;
      zang_type z;
      logic     neg;
   } cordic_state_type;

   function automatic zang_type atan_q24(input logic [STEP_W-1:0] i);
      case (i)
         5'd0:  atan_q24 = 28'sd13176795;
         5'd1:  atan_q24 = 28'sd7778716;
         5'd2:  atan_q24 = 28'sd4110060;
         5'd3:  atan_q24 = 28'sd2086331;
         5'd4:  atan_q24 = 28'sd1047214;
         5'd5:  atan_q24 = 28'sd524117;
         5'd6:  atan_q24 = 28'sd262123;
         5'd7:  atan_q24 = 28'sd131069;
         default: atan_q24 = zang_type'(28'sd1 <<< (5'd24 - i));
      endcase
   endfunction

   // Q30 x Q30 product rounded back to Q30, half up.
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [2*CORDIC_W-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      mul_q30 = q30_type'(p >>> 30);
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/euler_to_rotation_matrix_unit.sv @@
// Top level: ZYX Euler angles to 3x3 rotation matrix, streaming.
//
//  channel | dir | fields (tdata, low bit first)
//  req     | in  | roll_angle[17:0], pitch_angle[35:18], yaw_angle[53:36], pad to 56
//  rsp     | out | rot_00..rot_22, OW bits each, row-major, padded to bytes
//
// One item per cycle while the output is not stalled; 23 CORDIC stages (three
// lanes side by side), then two product stages and one round/saturate stage.
// Pipeline advances whenever the output register is empty or being taken,
// so rsp_tready low with a result waiting freezes every stage; req_tready
// follows the same enable.
// Reset clears the valid bits only; the datapath carries no reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_rotation_matrix_unit
   import e2r_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,   // roll, pitch, yaw angles (18 bits each)
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
   output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   localparam int OW      = OUT_FRAC_BITS + 2;
   localparam int DW      = ((9*OW+7)/8)*8;
   localparam int LATENCY = STEPS + 1 + 3;

   logic en;
   logic [LATENCY-1:0] vld_ff;
   q30_type s [3];
   q30_type c [3];
   logic signed [OW-1:0] rot [9];

   // stall the whole pipe only when a result sits unclaimed at the output
   assign en         = !(vld_ff[LATENCY-1] && !rsp_tready);
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      e2r_cordic_lane u_lane (
         .clock   (clock),
         .en      (en),
         .angle   (req_tdata[l*ANG_W +: ANG_W]),
         .sin_q30 (s[l]),
         .cos_q30 (c[l])
      );
   end

   e2r_matrix_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
      .clock (clock),
      .en    (en),
      .sr (s[0]), .cr (c[0]), .sp (s[1]), .cp (c[1]), .sy (s[2]), .cy (c[2]),
      .rot   (rot)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < 9; k++) rsp_tdata[k*OW +: OW] = rot[k];
   end

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> (9*OW)) == '0)
      else $error("padding not zero");
endmodule
`default_nettype wire

@@ rtl/core/e2r_cordic_lane.sv @@
// Pipelined rotation-mode CORDIC lane: sine and cosine of one Q2.15 angle.
`timescale 1ns / 1ps
`default_nettype none
module e2r_cordic_lane
   import e2r_pkg::*;
(
   input  wire                     clock,
   input  wire                     en,
   input  wire logic signed [ANG_W-1:0] angle,
   output q30_type                 sin_q30,
   output q30_type                 cos_q30
);
   cordic_state_type stage_ff [STEPS+1];
   cordic_state_type stage_in [STEPS+1];
   logic signed [ANG_W-1:0] clamp;
   zang_type z0;

   always_comb begin
      clamp = angle;
      if (angle > ANGLE_LIMIT) clamp = ANGLE_LIMIT;
      if (angle < -ANGLE_LIMIT) clamp = -ANGLE_LIMIT;
      z0 = zang_type'(clamp) <<< 9;
      stage_in[0].x = CORDIC_X0;
      stage_in[0].y = '0;
      stage_in[0].neg = 1'b0;
      stage_in[0].z = z0;
      if (z0 > Q24_HALF_PI) begin
         stage_in[0].z = z0 - Q24_PI;
         stage_in[0].neg = 1'b1;
      end else if (z0 < -Q24_HALF_PI) begin
         stage_in[0].z = z0 + Q24_PI;
         stage_in[0].neg = 1'b1;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_comb begin
         stage_in[i+1].neg = stage_ff[i].neg;
         if (!stage_ff[i].z[Z_W-1]) begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - atan_q24(STEP_W'(i));
         end else begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + atan_q24(STEP_W'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= STEPS; k++) stage_ff[k] <= stage_in[k];
      end
   end

   assign sin_q30 = stage_ff[STEPS].neg ? -stage_ff[STEPS].y : stage_ff[STEPS].y;
   assign cos_q30 = stage_ff[STEPS].neg ? -stage_ff[STEPS].x : stage_ff[STEPS].x;
endmodule
`default_nettype wire

@@ rtl/core/e2r_matrix_merge.sv @@
// Merge stage: combines the three lanes' sine/cosine into the nine entries.
`timescale 1ns / 1ps
`default_nettype none
module e2r_matrix_merge
   import e2r_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 16
) (
   input  wire     clock,
   input  wire     en,
   input  q30_type sr, cr, sp, cp, sy, cy,
   output logic signed [OUT_FRAC_BITS+1:0] rot [9]
);
   localparam int OW = OUT_FRAC_BITS + 2;
   localparam int SH = 30 - OUT_FRAC_BITS;
   localparam logic signed [CORDIC_W+1:0] LIM = (36'sd1 <<< OUT_FRAC_BITS);

   // stage A: first products
   q30_type cpcy_ff, cpsy_ff, crsy_ff, srsy_ff, crcy_ff, srcy_ff;
   q30_type srcp_ff, crcp_ff, srsp_ff, crsp_ff, nsp_ff, cya_ff, sya_ff;
   // stage B: triple products
   q30_type t1_ff, t2_ff, t4_ff, t5_ff;
   q30_type b_cpcy_ff, b_cpsy_ff, b_crsy_ff, b_srsy_ff, b_crcy_ff, b_srcy_ff;
   q30_type b_srcp_ff, b_crcp_ff, b_nsp_ff;
   logic signed [CORDIC_W+1:0] sum [9];

   function automatic logic signed [OW-1:0] emit(input logic signed [CORDIC_W+1:0] v);
      logic signed [CORDIC_W+1:0] r;
      r = (SH > 0) ? ((v + (36'sd1 <<< (SH - 1))) >>> SH) : v;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      emit = r[OW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         cpcy_ff <= mul_q30(cp, cy);  cpsy_ff <= mul_q30(cp, sy);
         crsy_ff <= mul_q30(cr, sy);  srsy_ff <= mul_q30(sr, sy);
         crcy_ff <= mul_q30(cr, cy);  srcy_ff <= mul_q30(sr, cy);
         srcp_ff <= mul_q30(sr, cp);  crcp_ff <= mul_q30(cr, cp);
         srsp_ff <= mul_q30(sr, sp);  crsp_ff <= mul_q30(cr, sp);
         nsp_ff  <= -sp; cya_ff <= cy; sya_ff <= sy;
         t1_ff <= mul_q30(srsp_ff, cya_ff);  t2_ff <= mul_q30(crsp_ff, cya_ff);
         t4_ff <= mul_q30(srsp_ff, sya_ff);  t5_ff <= mul_q30(crsp_ff, sya_ff);
         b_cpcy_ff <= cpcy_ff; b_cpsy_ff <= cpsy_ff; b_crsy_ff <= crsy_ff;
         b_srsy_ff <= srsy_ff; b_crcy_ff <= crcy_ff; b_srcy_ff <= srcy_ff;
         b_srcp_ff <= srcp_ff; b_crcp_ff <= crcp_ff; b_nsp_ff <= nsp_ff;
         for (int k = 0; k < 9; k++) rot[k] <= emit(sum[k]);
      end
   end

   always_comb begin
      sum[0] = 36'(b_cpcy_ff);
      sum[1] = 36'(t1_ff) - 36'(b_crsy_ff);
      sum[2] = 36'(b_srsy_ff) + 36'(t2_ff);
      sum[3] = 36'(b_cpsy_ff);
      sum[4] = 36'(b_crcy_ff) + 36'(t4_ff);
      sum[5] = 36'(t5_ff) - 36'(b_srcy_ff);
      sum[6] = 36'(b_nsp_ff);
      sum[7] = 36'(b_srcp_ff);
      sum[8] = 36'(b_crcp_ff);
   end
endmodule
`default_nettype wire

@@ tb/sv/tb_euler_to_rotation_matrix_unit.sv @@
// Testbench for the Euler-to-rotation-matrix unit: directed table, random angles, scoreboard.
`timescale 1ns / 1ps
module tb_euler_to_rotation_matrix_unit;
   import e2r_pkg::*;

   localparam int OFB     = 16;
   localparam int OW      = OFB + 2;
   localparam int RSP_W   = ((9*OW+7)/8)*8;
   localparam int LATENCY = 26;
   localparam int N_RAND  = 530;
   localparam longint CYCLE_LIMIT = 200000;
   localparam logic signed [17:0] PI_Q15 = 18'sd102944;

   typedef logic [9*OW-1:0] matrix_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [55:0]       req_tdata;   // roll, pitch, yaw (18 bits each, low first)
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // rot_00 .. rot_22, row-major, low first

   euler_to_rotation_matrix_unit #(.OUT_FRAC_BITS(OFB)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   matrix_type expected_matrices[$];
   int         mismatch_count;
   longint     cycle_count;
   bit         idle_enable;

   // Predictor: rotation-mode CORDIC in Q30 after folding the angle into +-pi/2.
   function automatic void sin_cos(input logic signed [17:0] ang,
                                   output longint s, output longint c);
      longint z, x, y, nx, a;
      bit     flip;
      a = ang;
      if (a > 102944) a = 102944;
      if (a < -102944) a = -102944;
      z = a * 512;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 26353589) begin
         z -= 52707179; flip = 1;
      end else if (z < -26353589) begin
         z += 52707179; flip = 1;
      end
      for (int i = 0; i < 22; i++) begin
         longint at;
         case (i)
            0: at = 13176795;
            1: at = 7778716;
            2: at = 4110060;
            3: at = 2086331;
            4: at = 1047214;
            5: at = 524117;
            6: at = 262123;
            7: at = 131069;
            default: at = longint'(1) << (24 - i);
         endcase
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= at;
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += at;
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint prod_q30(input longint a, input longint b);
      return (a * b + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic logic [OW-1:0] to_entry(input longint v);
      longint lim;
      lim = longint'(1) << OFB;
      v = (v + (longint'(1) << (29 - OFB))) >>> (30 - OFB);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[OW-1:0];
   endfunction

   function automatic matrix_type rotation_of(input logic [55:0] angles);
      longint sr, cr, sp, cp, sy, cy, srsp, crsp;
      matrix_type m;
      sin_cos(angles[17:0], sr, cr);
      sin_cos(angles[35:18], sp, cp);
      sin_cos(angles[53:36], sy, cy);
      srsp = prod_q30(sr, sp);
      crsp = prod_q30(cr, sp);
      m[0*OW +: OW] = to_entry(prod_q30(cp, cy));
      m[1*OW +: OW] = to_entry(prod_q30(srsp, cy) - prod_q30(cr, sy));
      m[2*OW +: OW] = to_entry(prod_q30(sr, sy) + prod_q30(crsp, cy));
      m[3*OW +: OW] = to_entry(prod_q30(cp, sy));
      m[4*OW +: OW] = to_entry(prod_q30(cr, cy) + prod_q30(srsp, sy));
      m[5*OW +: OW] = to_entry(prod_q30(crsp, sy) - prod_q30(sr, cy));
      m[6*OW +: OW] = to_entry(-sp);
      m[7*OW +: OW] = to_entry(prod_q30(sr, cp));
      m[8*OW +: OW] = to_entry(prod_q30(cr, cp));
      return m;
   endfunction

   function automatic logic [17:0] random_angle();
      case ($urandom_range(0, 9))
         0: return 18'($urandom);                         // any pattern, may clamp
         1: return 18'($urandom_range(0, 200)) + 18'(102844);
         2: return -18'($urandom_range(0, 200)) - 18'(102844);
         3: return 18'(26353589 / 512) + 18'($urandom_range(0, 4)) - 18'd2;
         default: return 18'(int'($urandom_range(0, 205888)) - 102944);
      endcase
   endfunction

   // Directed rows: angle triple, and an expected matrix where it is obvious.
   typedef struct {
      logic [17:0] roll, pitch, yaw;
      bit          has_fixed;
      matrix_type  fixed;
   } stim_row_type;

   localparam logic [OW-1:0] ONE  = OW'(1 << OFB);

   stim_row_type directed_rows[$];
   matrix_type   identity;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle limit and result checking.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_euler_to_rotation_matrix_unit: done, errors");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matrices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item %h", rsp_tdata);
         end else begin
            matrix_type want;
            want = expected_matrices.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_tdata[k*OW +: OW] !== want[k*OW +: OW]) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("rot entry %0d: expected %h got %h", k,
                              want[k*OW +: OW], rsp_tdata[k*OW +: OW]);
               end
            if (rsp_tdata[RSP_W-1:9*OW] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("pad bits not zero");
            end
         end
      end
   end

   // Receiver stall in bursts.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_angles(input logic [17:0] r, p, y, input bit use_fixed,
                              input matrix_type fixed);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, y, p, r};
      do @(posedge clock); while (!req_tready);
      expected_matrices.push_back(use_fixed ? fixed : rotation_of({2'b00, y, p, r}));
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatch_count = 0;
      cycle_count = 0;
      idle_enable = 1'b1;

      identity = '0;
      identity[0*OW +: OW] = ONE;
      identity[4*OW +: OW] = ONE;
      identity[8*OW +: OW] = ONE;
      // zero angles give the identity
      directed_rows.push_back('{18'd0, 18'd0, 18'd0, 1'b1, identity});
      // extremes and clamping: +-pi, most positive and negative patterns
      directed_rows.push_back('{PI_Q15, 18'd0, 18'd0, 1'b0, '0});
      directed_rows.push_back('{-PI_Q15, 18'd0, 18'd0, 1'b0, '0});
      directed_rows.push_back('{18'h1ffff, 18'h20000, 18'h1ffff, 1'b0, '0});
      directed_rows.push_back('{18'h20000, 18'h1ffff, 18'h20000, 1'b0, '0});
      directed_rows.push_back('{18'h3ffff, 18'h3ffff, 18'h3ffff, 1'b0, '0});
      directed_rows.push_back('{18'd0, PI_Q15 + 18'd1, 18'd0, 1'b0, '0});
      directed_rows.push_back('{18'd0, 18'd0, -PI_Q15 - 18'd1, 1'b0, '0});
      // quarter turns, near the fold at pi/2
      directed_rows.push_back('{18'd51472, 18'd0, 18'd0, 1'b0, '0});
      directed_rows.push_back('{18'd0, 18'd51472, 18'd0, 1'b0, '0});
      directed_rows.push_back('{18'd0, 18'd51473, 18'd0, 1'b0, '0});
      directed_rows.push_back('{18'd0, -18'd51472, 18'd0, 1'b0, '0});
      directed_rows.push_back('{18'd0, 18'd0, 18'd51471, 1'b0, '0});
      directed_rows.push_back('{18'd0, 18'd0, -18'd51473, 1'b0, '0});
      // rounding overshoot likely near cos = 1 products
      directed_rows.push_back('{18'd1, 18'd1, 18'd1, 1'b0, '0});
      directed_rows.push_back('{-18'd1, -18'd1, -18'd1, 1'b0, '0});
      directed_rows.push_back('{PI_Q15, PI_Q15, PI_Q15, 1'b0, '0});
      directed_rows.push_back('{18'd25736, 18'd12868, -18'd38604, 1'b0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_angles(directed_rows[i].roll, directed_rows[i].pitch, directed_rows[i].yaw,
                     directed_rows[i].has_fixed, directed_rows[i].fixed);

      for (int n = 0; n < N_RAND; n++) begin
         if (n == N_RAND - 80) idle_enable = 1'b0;   // full-rate tail
         send_angles(random_angle(), random_angle(), random_angle(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (expected_matrices.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);

      if (mismatch_count == 0 && expected_matrices.size() == 0)
         $display("tb_euler_to_rotation_matrix_unit: done, clean");
      else
         $display("tb_euler_to_rotation_matrix_unit: done, errors");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/e2r_pkg.sv
rtl/core/e2r_cordic_lane.sv
rtl/core/e2r_matrix_merge.sv
rtl/core/euler_to_rotation_matrix_unit.sv
tb/sv/tb_euler_to_rotation_matrix_unit.sv
